FILE: rtl/core/ict_pkg.sv
// Shared types, codes and the character classifier of the configuration text tokenizer.
package ict_pkg;

  typedef enum logic [3:0] {
    ST_EXPECT_NAME  = 4'd0,
    ST_SECTION      = 4'd1,
    ST_NAME         = 4'd2,
    ST_COMMENT      = 4'd3,
    ST_EXPECT_EQ    = 4'd4,
    ST_EXPECT_VALUE = 4'd5,
    ST_VALUE        = 4'd6,
    ST_QUOTED       = 4'd7,
    ST_EXPECT_EOL   = 4'd8
  } ict_state_t;

  typedef enum logic [3:0] {
    K_SPACE = 4'd0,
    K_WORD  = 4'd1,
    K_EQ    = 4'd2,
    K_QUOTE = 4'd3,
    K_OPEN  = 4'd4,
    K_CLOSE = 4'd5,
    K_HASH  = 4'd6,
    K_ESC   = 4'd7,
    K_EOL   = 4'd8,
    K_OTHER = 4'd9
  } ict_class_t;

  typedef enum logic [2:0] {
    R_NONE       = 3'd0,
    R_SEC_CLEAR  = 3'd1,
    R_SEC_CHAR   = 3'd2,
    R_NAME_START = 3'd3,
    R_NAME_CHAR  = 3'd4,
    R_VAL_CLEAR  = 3'd5,
    R_VAL_START  = 3'd6,
    R_VAL_CHAR   = 3'd7
  } ict_role_t;

  typedef enum logic [2:0] {
    E_ITEM_NAME = 3'd0,
    E_CLOSE     = 3'd1,
    E_EQUALS    = 3'd2,
    E_VALUE     = 3'd3,
    E_EOL       = 3'd4,
    E_QUOTE     = 3'd5
  } ict_err_t;

  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_OPEN   = 8'h5B;
  localparam logic [7:0] CH_CLOSE  = 8'h5D;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef struct packed {
    ict_role_t   role;
    logic [7:0]  out_char;
    logic        commit;
    logic        error;
    ict_err_t    error_kind;
    logic [15:0] error_line;
    logic [15:0] error_column;
  } ict_res_t;

  function automatic ict_class_t ict_classify(input logic [7:0] c);
    ict_class_t k;
    k = K_OTHER;
    if (c == CH_LF) k = K_EOL;
    else if (c == CH_SP || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR) k = K_SPACE;
    else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)) k = K_WORD;
    else if (c >= 8'h30 && c <= 8'h39) k = K_WORD;
    else if (c == CH_DASH || c == CH_UNDER) k = K_WORD;
    else if (c == CH_EQ) k = K_EQ;
    else if (c == CH_QUOTE) k = K_QUOTE;
    else if (c == CH_OPEN) k = K_OPEN;
    else if (c == CH_CLOSE) k = K_CLOSE;
    else if (c == CH_HASH) k = K_HASH;
    else if (c == CH_BSLASH) k = K_ESC;
    return k;
  endfunction

endpackage

FILE: rtl/core/ini_config_tokenizer.sv
// Top level of the INI-style configuration text tokenizer.
// Takes one text byte per cycle while in_tready is high and returns one result word per byte
// from a registered stage; parser state and counters advance per byte, so a new byte can be
// taken on every clock, and a two-entry output stage keeps input flowing while a result waits
// on a stalled consumer. in_tready drops only when both output entries are occupied. A word
// with in_tlast applies the end-of-stream rules and returns the parser to its reset state;
// after a syntax error all bytes up to and including the last one give all-zero results.
module ini_config_tokenizer import ict_pkg::*; #(
  parameter int LINE_BITS   = 16,
  parameter int COLUMN_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] out_char, [8] commit, [9] error,
                                  // [12:10] error_kind, [28:13] error_line,
                                  // [44:29] error_column, [47:45] zero
  output logic [2:0]  out_tuser   // [2:0] role
);

  ict_res_t res, head;
  logic     take, can_push;

  assign in_tready = can_push;
  assign take      = in_tvalid && can_push;

  ict_parser #(
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .ch      (in_tdata),
    .is_last (in_tlast),
    .res     (res)
  );

  ict_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (head)
  );

  assign out_tuser = head.role;
  assign out_tdata = {3'b000, head.error_column, head.error_line, head.error_kind,
                      head.error, head.commit, head.out_char};

endmodule

FILE: rtl/core/ict_parser.sv
// Parser state, line and column counters and the per-word transition logic.
module ict_parser import ict_pkg::*; #(
  parameter int LINE_BITS   = 16,
  parameter int COLUMN_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] ch,
  input  logic       is_last,
  output ict_res_t   res
);

  ict_state_t             state_r, state_nxt;
  logic                   esc_r, esc_nxt;
  logic                   halted_r, halted_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [COLUMN_BITS-1:0] col_r, col_nxt;

  ict_class_t             k;
  ict_state_t             st;
  logic                   esc;
  logic [LINE_BITS-1:0]   line_v;
  logic [COLUMN_BITS-1:0] col_v;
  ict_role_t              role;
  ict_err_t               kind;
  logic                   commit, err;
  logic [31:0]            line_ext, col_ext;

  assign k = ict_classify(ch);

  always_comb begin
    st     = state_r;
    esc    = esc_r;
    line_v = line_r;
    col_v  = col_r;
    role   = R_NONE;
    kind   = E_ITEM_NAME;
    commit = 1'b0;
    err    = 1'b0;
    if (!halted_r) begin
      if (col_r != '1) col_v = col_r + COLUMN_BITS'(1);
      unique case (state_r)
        ST_EXPECT_NAME: begin
          if (k == K_WORD) begin st = ST_NAME; role = R_NAME_START; end
          else if (k == K_OPEN) begin st = ST_SECTION; role = R_SEC_CLEAR; end
          else if (k == K_HASH) st = ST_COMMENT;
          else if (k != K_SPACE && k != K_EOL) begin err = 1'b1; kind = E_ITEM_NAME; end
        end
        ST_SECTION: begin
          if (k == K_WORD) role = R_SEC_CHAR;
          else if (k == K_CLOSE) st = ST_EXPECT_EOL;
          else begin err = 1'b1; kind = E_CLOSE; end
        end
        ST_NAME: begin
          if (k == K_WORD) role = R_NAME_CHAR;
          else if (k == K_EQ) st = ST_EXPECT_VALUE;
          else if (k == K_SPACE) st = ST_EXPECT_EQ;
          else begin err = 1'b1; kind = E_EQUALS; end
        end
        ST_COMMENT: begin
          if (k == K_EOL) st = ST_EXPECT_NAME;
        end
        ST_EXPECT_EQ: begin
          if (k == K_EQ) st = ST_EXPECT_VALUE;
          else if (k != K_SPACE) begin err = 1'b1; kind = E_EQUALS; end
        end
        ST_EXPECT_VALUE: begin
          if (k == K_WORD) begin st = ST_VALUE; role = R_VAL_START; end
          else if (k == K_QUOTE) begin st = ST_QUOTED; role = R_VAL_CLEAR; end
          else if (k == K_EOL) begin
            st = ST_EXPECT_NAME; role = R_VAL_CLEAR; commit = 1'b1;
          end
          else if (k != K_SPACE) begin err = 1'b1; kind = E_VALUE; end
        end
        ST_VALUE: begin
          if (k == K_QUOTE) begin err = 1'b1; kind = E_VALUE; end
          else if (k == K_SPACE) begin st = ST_EXPECT_EOL; commit = 1'b1; end
          else if (k == K_EOL) begin st = ST_EXPECT_NAME; commit = 1'b1; end
          else if (k == K_HASH) begin st = ST_COMMENT; commit = 1'b1; end
          else role = R_VAL_CHAR;
        end
        ST_QUOTED: begin
          if (esc_r) begin role = R_VAL_CHAR; esc = 1'b0; end
          else if (k == K_QUOTE) begin st = ST_EXPECT_EOL; commit = 1'b1; end
          else if (k == K_ESC) esc = 1'b1;
          else role = R_VAL_CHAR;
        end
        ST_EXPECT_EOL: begin
          if (k == K_HASH) st = ST_COMMENT;
          else if (k == K_EOL) st = ST_EXPECT_NAME;
          else if (k != K_SPACE) begin err = 1'b1; kind = E_EOL; end
        end
        default: st = ST_EXPECT_NAME;
      endcase
      if (!err) begin
        if (k == K_EOL) begin
          if (line_r != '1) line_v = line_r + LINE_BITS'(1);
          col_v = '0;
        end
        // End-of-stream rules look at the state this word has just left behind.
        if (is_last) begin
          if (st == ST_QUOTED) begin err = 1'b1; kind = E_QUOTE; end
          else if (st == ST_VALUE) commit = 1'b1;
          else if (st == ST_EXPECT_VALUE) begin role = R_VAL_CLEAR; commit = 1'b1; end
        end
      end
    end
  end

  assign line_ext = 32'(line_v);
  assign col_ext  = 32'(col_v);

  always_comb begin
    res.role       = role;
    res.commit     = commit;
    res.error      = err;
    res.error_kind = err ? kind : E_ITEM_NAME;
    res.error_line = err ? ((line_ext > 32'hFFFF) ? 16'hFFFF : line_ext[15:0]) : 16'd0;
    res.error_column = err ? ((col_ext > 32'hFFFF) ? 16'hFFFF : col_ext[15:0]) : 16'd0;
    res.out_char   = (role == R_SEC_CHAR || role == R_NAME_START || role == R_NAME_CHAR ||
                      role == R_VAL_START || role == R_VAL_CHAR) ? ch : 8'd0;
  end

  always_comb begin
    state_nxt  = state_r;
    esc_nxt    = esc_r;
    halted_nxt = halted_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    if (take) begin
      if (is_last) begin
        state_nxt  = ST_EXPECT_NAME;
        esc_nxt    = 1'b0;
        halted_nxt = 1'b0;
        line_nxt   = LINE_BITS'(1);
        col_nxt    = '0;
      end else if (!halted_r) begin
        state_nxt  = st;
        esc_nxt    = esc;
        halted_nxt = err;
        line_nxt   = line_v;
        col_nxt    = col_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_EXPECT_NAME;
      esc_r    <= 1'b0;
      halted_r <= 1'b0;
      line_r   <= LINE_BITS'(1);
      col_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      esc_r    <= esc_nxt;
      halted_r <= halted_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
    end
  end

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    take && is_last |=> state_r == ST_EXPECT_NAME && !halted_r && !esc_r)
    else $error("parser not back in its reset state after the last word");

  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r && !(take && is_last) |=> halted_r)
    else $error("halt released before the last word");

  a_esc_quoted: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> state_r == ST_QUOTED && !halted_r)
    else $error("escape pending outside a quoted value");

  a_err_no_commit: assert property (@(posedge clk) disable iff (!rst_n)
    take && res.error |-> !res.commit && !halted_r)
    else $error("error reported together with a commit or while halted");

endmodule

FILE: rtl/core/ict_obuf.sv
// Two-entry output register with skid slot for the result words.
module ict_obuf import ict_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  ict_res_t push_data,
  output logic     can_push,
  output logic     out_valid,
  input  logic     out_ready,
  output ict_res_t out_data
);

  logic [1:0] cnt_r, cnt_nxt;
  ict_res_t   head_r, skid_r;
  logic       pop;

  assign can_push  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = head_r;
  assign pop       = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= 2'd0;
    else cnt_r <= cnt_nxt;
  end

  // The head always holds the oldest word; the skid slot fills only when the head is stalled.
  always_ff @(posedge clk) begin
    if (cnt_r == 2'd2) begin
      if (pop) head_r <= skid_r;
    end else if (push) begin
      if (cnt_r == 2'd0 || pop) head_r <= push_data;
      else skid_r <= push_data;
    end
  end

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> out_valid)
    else $error("accepted word not visible at the output");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && cnt_r == 2'd1 && push |=> !can_push)
    else $error("skid slot overrun");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("word count out of range");

endmodule
